### rtl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants of the Helmholtz potential sum
// Beat payload structs, fixed-point constants, the CORDIC arctangent table
// and the 48-bit saturating add.
// ----------------------------------------------------------------------------
package hps_pkg;

  // One input beat: target, one source and the target's prior potential.
  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] source_strength;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic signed [47:0] prior_phi_real;
    logic signed [47:0] prior_phi_imag;
    logic               last_source;
  } hps_in_t;

  // One result beat: updated potential, Q24.24.
  typedef struct packed {
    logic signed [47:0] phi_real;
    logic signed [47:0] phi_imag;
  } hps_out_t;

  localparam logic [31:0]        WAVENUMBER_RST = 32'h0100_0000;
  localparam logic [63:0]        INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
  localparam logic signed [33:0] CORDIC_GAIN    = 34'sh0_26DD_3B6A;
  localparam logic signed [47:0] SAT_MAX        = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SAT_MIN        = 48'sh8000_0000_0000;

  // Arctangent of 2^-i in turns, 2^32 per turn.
  function automatic logic signed [32:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h2000_0000;
      5'd1:  v = 32'h12E4_051E;
      5'd2:  v = 32'h09FB_385B;
      5'd3:  v = 32'h0511_11D4;
      5'd4:  v = 32'h028B_0D43;
      5'd5:  v = 32'h0145_D7E1;
      5'd6:  v = 32'h00A2_F61E;
      5'd7:  v = 32'h0051_7C55;
      5'd8:  v = 32'h0028_BE53;
      5'd9:  v = 32'h0014_5F2F;
      5'd10: v = 32'h000A_2F98;
      5'd11: v = 32'h0005_17CC;
      5'd12: v = 32'h0002_8BE6;
      5'd13: v = 32'h0001_45F3;
      5'd14: v = 32'h0000_A2FA;
      5'd15: v = 32'h0000_517D;
      5'd16: v = 32'h0000_28BE;
      5'd17: v = 32'h0000_145F;
      5'd18: v = 32'h0000_0A30;
      5'd19: v = 32'h0000_0518;
      5'd20: v = 32'h0000_028C;
      5'd21: v = 32'h0000_0146;
      5'd22: v = 32'h0000_00A3;
      5'd23: v = 32'h0000_0051;
      5'd24: v = 32'h0000_0029;
      5'd25: v = 32'h0000_0014;
      5'd26: v = 32'h0000_000A;
      5'd27: v = 32'h0000_0005;
      5'd28: v = 32'h0000_0003;
      5'd29: v = 32'h0000_0001;
      5'd30: v = 32'h0000_0001;
      default: v = 32'h0000_0000;
    endcase
    return $signed({1'b0, v});
  endfunction

  // Signed 48-bit add that clamps to the representable range.
  function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      return s[48] ? SAT_MIN : SAT_MAX;
    end
    return s[47:0];
  endfunction

endpackage

### rtl/hps_isqrt.sv
// ----------------------------------------------------------------------------
// hps_isqrt: bit-serial integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module hps_isqrt import hps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v_r;
  logic [32:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;
  logic [34:0] rem_nxt;

  // One restoring step: bring down two bits and try root*4+1.
  always_comb begin
    rem_sh  = {rem_r, v_r[63:62]};
    trial   = {1'b0, root_r, 2'b01};
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        v_r    <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        v_r    <= {v_r[61:0], 2'b00};
        rem_r  <= rem_nxt[32:0];
        root_r <= {root_r[30:0], ge};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/hps_cordic.sv
// ----------------------------------------------------------------------------
// hps_cordic: iterative CORDIC rotator
// Rotates the prescaled unit vector by an angle in turns, one step per
// cycle, giving cosine and sine in Q1.30.
// ----------------------------------------------------------------------------
module hps_cordic import hps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [29:0]        angle,
  output logic               done,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [32:0] z_r;
  logic [4:0]         i_r;
  logic               busy_r;
  logic               done_r;

  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] x_nxt;
  logic signed [33:0] y_nxt;
  logic signed [32:0] z_nxt;

  // Micro-rotation toward zero residual angle; shifts floor.
  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    if (!z_r[32]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_turns(i_r);
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_turns(i_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= $signed({3'b000, angle});
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        i_r <= i_r + 5'd1;
        if (i_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign cos_o = x_r;
  assign sin_o = y_r;

endmodule

### rtl/hps_div.sv
// ----------------------------------------------------------------------------
// hps_div: bit-serial unsigned divider
// Divides a 66-bit dividend by a 50-bit divisor. Quotients of 2^48 or more
// are flagged as overflow at once; otherwise 48 restoring steps follow.
// ----------------------------------------------------------------------------
module hps_div import hps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [65:0] dividend,
  input  logic [49:0] divisor,
  output logic        done,
  output logic        ovf,
  output logic [47:0] quot
);

  logic [49:0] div_r;
  logic [49:0] rem_r;
  logic [47:0] n_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic        ovf_r;

  logic        pre_ovf;
  logic [50:0] t;
  logic        ge;
  logic [50:0] rem_nxt;

  // Upper part already at least the divisor means the quotient exceeds 48 bits.
  assign pre_ovf = ({32'b0, dividend[65:48]} >= divisor);

  // One restoring step.
  always_comb begin
    t       = {rem_r, n_r[47]};
    ge      = (t >= {1'b0, div_r});
    rem_nxt = ge ? (t - {1'b0, div_r}) : t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ovf_r <= pre_ovf;
        div_r <= divisor;
        rem_r <= {32'b0, dividend[65:48]};
        n_r   <= dividend[47:0];
        cnt_r <= '0;
        if (pre_ovf) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt[49:0];
        n_r   <= {n_r[46:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign ovf  = ovf_r;
  assign quot = n_r;

endmodule

### rtl/helmholtz_potential_sum.sv
// ----------------------------------------------------------------------------
// helmholtz_potential_sum: direct-sum Helmholtz kernel for one target
// Per source beat: distance, x = k*d, sin(x)/x and cos(x)/x weighted by the
// source strength, added to saturating sums; the last beat emits the result.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   in_       input      in_valid / in_ready     hps_in_t  (one source)
//   out_      output     out_valid / out_ready   hps_out_t (on last source)
//   cfg_      input      cfg_valid / cfg_ready   32-bit wavenumber, Q8.24
//
// A source beat runs the 32-step square root, the 32-step CORDIC rotation and
// two 48-step divisions one after another; a division flagged as overflow
// runs no steps, and a source whose x is zero skips rotation and divisions.
// Reset is synchronous: sums cleared, wavenumber set to 1.0.
// A result waits in the output register; a new beat is taken meanwhile, and
// the next result stalls only while that register is still full.
// ----------------------------------------------------------------------------
module helmholtz_potential_sum import hps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  hps_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output hps_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AccW = 114;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_KD, ST_TURN, ST_ROT, ST_TERM,
    ST_DIV_RE, ST_DIV_IM, ST_FIN
  } state_t;

  state_t             state_r;
  logic [1:0]         step_r;
  logic [31:0]        wn_r;
  logic [30:0]        ax_r, ay_r, az_r;
  logic [1:0]         sh_r;
  logic signed [31:0] str_r;
  logic signed [47:0] prior_re_r, prior_im_r;
  logic               last_r;
  logic [AccW-1:0]    acc_r;
  logic [33:0]        d_r;
  logic [49:0]        x24_r;
  logic [31:0]        turns_r;
  logic signed [33:0] sn_r, cs_r;
  logic [63:0]        tre_r, tim_r;
  logic               neg_re_r, neg_im_r;
  logic signed [47:0] sum_re_r, sum_im_r;
  logic               out_valid_r;
  hps_out_t           out_data_r;

  // Deltas and their range reduction on the accepted beat.
  logic signed [32:0] dx, dy, dz;
  logic [32:0]        ax, ay, az, mx;
  logic [1:0]         sh;
  logic [32:0]        axs, ays, azs;

  always_comb begin
    dx  = {in_data.source_x[31], in_data.source_x} - {in_data.target_x[31], in_data.target_x};
    dy  = {in_data.source_y[31], in_data.source_y} - {in_data.target_y[31], in_data.target_y};
    dz  = {in_data.source_z[31], in_data.source_z} - {in_data.target_z[31], in_data.target_z};
    ax  = dx[32] ? 33'(-dx) : 33'(dx);
    ay  = dy[32] ? 33'(-dy) : 33'(dy);
    az  = dz[32] ? 33'(-dz) : 33'(dz);
    mx  = ax;
    if (ay > mx) begin
      mx = ay;
    end
    if (az > mx) begin
      mx = az;
    end
    sh  = mx[32] ? 2'd2 : (mx[31] ? 2'd1 : 2'd0);
    axs = ax >> sh;
    ays = ay >> sh;
    azs = az >> sh;
  end

  // Shared 32x32 multiplier with a shifting accumulator.
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     prod;
  logic            mac_clr;
  logic [1:0]      mac_sh;
  logic [AccW-1:0] pp;
  logic [AccW-1:0] acc_nxt;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mac_clr = 1'b0;
    mac_sh  = 2'd0;
    case (state_r)
      ST_SQ: begin
        mac_clr = (step_r == 2'd0);
        case (step_r)
          2'd0:    begin mul_a = {1'b0, ax_r}; mul_b = {1'b0, ax_r}; end
          2'd1:    begin mul_a = {1'b0, ay_r}; mul_b = {1'b0, ay_r}; end
          default: begin mul_a = {1'b0, az_r}; mul_b = {1'b0, az_r}; end
        endcase
      end
      ST_KD: begin
        mul_a = wn_r;
        if (step_r == 2'd0) begin
          mac_clr = 1'b1;
          mul_b   = d_r[31:0];
        end else begin
          mac_sh = 2'd1;
          mul_b  = {30'b0, d_r[33:32]};
        end
      end
      ST_TURN: begin
        case (step_r)
          2'd0: begin
            mac_clr = 1'b1;
            mul_a   = x24_r[31:0];
            mul_b   = INV_TWO_PI_Q64[31:0];
          end
          2'd1: begin
            mac_sh = 2'd1;
            mul_a  = x24_r[31:0];
            mul_b  = INV_TWO_PI_Q64[63:32];
          end
          2'd2: begin
            mac_sh = 2'd1;
            mul_a  = {14'b0, x24_r[49:32]};
            mul_b  = INV_TWO_PI_Q64[31:0];
          end
          default: begin
            mac_sh = 2'd2;
            mul_a  = {14'b0, x24_r[49:32]};
            mul_b  = INV_TWO_PI_Q64[63:32];
          end
        endcase
      end
      ST_TERM: begin
        mul_a = str_r[31] ? 32'(-str_r) : 32'(str_r);
        if (step_r == 2'd0) begin
          mul_b = sn_r[33] ? 32'(-sn_r) : 32'(sn_r);
        end else begin
          mul_b = cs_r[33] ? 32'(-cs_r) : 32'(cs_r);
        end
      end
      default: begin
        mul_a = '0;
      end
    endcase
    prod = mul_a * mul_b;
    case (mac_sh)
      2'd0:    pp = AccW'(prod);
      2'd1:    pp = AccW'({prod, 32'b0});
      default: pp = AccW'({prod, 64'b0});
    endcase
    acc_nxt = (mac_clr ? '0 : acc_r) + pp;
  end

  // Iterative units.
  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic        cordic_start, cordic_done;
  logic signed [33:0] cordic_cos, cordic_sin;
  logic        div_start, div_done, div_ovf;
  logic [47:0] div_quot;
  logic [65:0] div_dvd;

  assign sqrt_start   = (state_r == ST_SQ) && (step_r == 2'd2);
  assign cordic_start = (state_r == ST_TURN) && (step_r == 2'd3);
  assign div_start    = ((state_r == ST_TERM) && (step_r == 2'd1)) ||
                        ((state_r == ST_DIV_RE) && div_done);
  assign div_dvd      = (state_r == ST_TERM) ? {tre_r, 2'b00} : {tim_r, 2'b00};

  hps_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (acc_nxt[63:0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  hps_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (acc_nxt[85:56]),
    .done  (cordic_done),
    .cos_o (cordic_cos),
    .sin_o (cordic_sin)
  );

  hps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (x24_r),
    .done     (div_done),
    .ovf      (div_ovf),
    .quot     (div_quot)
  );

  // Signed, clamped quotient for the sum currently being divided.
  logic               q_neg;
  logic signed [47:0] q_s;

  always_comb begin
    q_neg = (state_r == ST_DIV_RE) ? neg_re_r : neg_im_r;
    if (div_ovf) begin
      q_s = q_neg ? SAT_MIN : SAT_MAX;
    end else if (q_neg) begin
      q_s = (div_quot > 48'h8000_0000_0000) ? SAT_MIN : $signed(-div_quot);
    end else begin
      q_s = div_quot[47] ? SAT_MAX : $signed(div_quot);
    end
  end

  logic fin_go;
  assign fin_go = !out_valid_r || out_ready;

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      wn_r        <= WAVENUMBER_RST;
      sum_re_r    <= '0;
      sum_im_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        wn_r <= cfg_data;
      end
      // The output register fills on an emitted result and empties on an accepted beat.
      if (state_r == ST_FIN && last_r && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE,
        ST_SQRT,
        ST_ROT,
        ST_DIV_RE,
        ST_DIV_IM,
        ST_FIN: begin
        end
        default: begin
          acc_r <= acc_nxt;
        end
      endcase
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            ax_r       <= axs[30:0];
            ay_r       <= ays[30:0];
            az_r       <= azs[30:0];
            sh_r       <= sh;
            str_r      <= in_data.source_strength;
            prior_re_r <= in_data.prior_phi_real;
            prior_im_r <= in_data.prior_phi_imag;
            last_r     <= in_data.last_source;
            step_r     <= '0;
            state_r    <= ST_SQ;
          end
        end
        ST_SQ: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd2) begin
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            d_r     <= 34'(sqrt_root) << sh_r;
            step_r  <= '0;
            state_r <= ST_KD;
          end
        end
        ST_KD: begin
          if (step_r == 2'd1) begin
            x24_r  <= acc_nxt[65:16];
            step_r <= '0;
            // A zero argument contributes nothing.
            state_r <= (acc_nxt[65:16] == '0) ? ST_FIN : ST_TURN;
          end else begin
            step_r <= step_r + 2'd1;
          end
        end
        ST_TURN: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            turns_r <= acc_nxt[87:56];
            state_r <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (cordic_done) begin
            // Fold the first-quadrant result into the full circle.
            case (turns_r[31:30])
              2'd0: begin sn_r <= cordic_sin;  cs_r <= cordic_cos;  end
              2'd1: begin sn_r <= cordic_cos;  cs_r <= -cordic_sin; end
              2'd2: begin sn_r <= -cordic_sin; cs_r <= -cordic_cos; end
              default: begin sn_r <= -cordic_cos; cs_r <= cordic_sin; end
            endcase
            step_r  <= '0;
            state_r <= ST_TERM;
          end
        end
        ST_TERM: begin
          if (step_r == 2'd0) begin
            tre_r    <= prod;
            neg_re_r <= str_r[31] ^ sn_r[33];
            step_r   <= step_r + 2'd1;
          end else begin
            tim_r    <= prod;
            neg_im_r <= str_r[31] ^ cs_r[33];
            step_r   <= '0;
            state_r  <= ST_DIV_RE;
          end
        end
        ST_DIV_RE: begin
          if (div_done) begin
            sum_re_r <= sat_add48(sum_re_r, q_s);
            state_r  <= ST_DIV_IM;
          end
        end
        ST_DIV_IM: begin
          if (div_done) begin
            sum_im_r <= sat_add48(sum_im_r, q_s);
            state_r  <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!last_r) begin
            state_r <= ST_IDLE;
          end else if (fin_go) begin
            out_data_r.phi_real <= sat_add48(prior_re_r, sum_re_r);
            out_data_r.phi_imag <= sat_add48(prior_im_r, sum_im_r);
            sum_re_r            <= '0;
            sum_im_r            <= '0;
            state_r             <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sequencer is busy in the cycle after it accepts a source beat.
  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input beat accepted while the sequencer was busy");

  // The rotator only finishes while the sequencer waits for it.
  a_cordic_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_done |-> (state_r == ST_ROT))
    else $error("rotation finished outside its wait state");

  // The divider only finishes while one of the sums is being divided.
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_RE || state_r == ST_DIV_IM))
    else $error("division finished outside its wait states");

  // Emitting a result clears both sums and fills the output register.
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && last_r && fin_go) |=>
      (sum_re_r == '0 && sum_im_r == '0 && out_valid_r))
    else $error("result emitted without clearing the sums");

endmodule

### tb/helmholtz_potential_sum_tb.sv
// ----------------------------------------------------------------------------
// helmholtz_potential_sum_tb: self-checking bench for the Helmholtz kernel
// Source beats are fed from a queue with random gaps. Results are drained with
// random stalls and one long hold-off. Each result is checked against a bit-exact
// software model of the distance, CORDIC sine and cosine, and division path.
// The bench steps through several wavenumber settings between phases.
// ----------------------------------------------------------------------------
module helmholtz_potential_sum_tb;
  import hps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint POS48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint NEG48 = -POS48 - 1;
  localparam int     DRAIN_CYCLES = 400;
  localparam int     CYCLE_LIMIT  = 2000000;
  localparam longint ATAN_T [0:31] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  hps_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  hps_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  hps_in_t     source_beats[$];
  hps_out_t    potentials_due[$];
  logic [31:0] wavenumber_now;
  longint      sum_re = 0;
  longint      sum_im = 0;
  int          sender_idle_pct;
  int          recv_stall_pct;
  logic        hold_off = 1'b0;
  int          failures = 0;
  int          beats_sent = 0;
  int          results_seen = 0;
  int          cycles = 0;

  helmholtz_potential_sum dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp48(input longint v);
    if (v > POS48) return POS48;
    if (v < NEG48) return NEG48;
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // CORDIC rotation on the low 30 bits of the angle, folded by quadrant.
  function automatic void sin_cos(input logic [31:0] turns, output longint sn,
                                  output longint cs);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    x = 64'h26DD3B6A;
    y = 0;
    z = longint'({34'd0, turns[29:0]});
    for (int i = 0; i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_T[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_T[i];
      end
    end
    case (turns[31:30])
      2'd0: begin sn = y;  cs = x;  end
      2'd1: begin sn = x;  cs = -y; end
      2'd2: begin sn = -y; cs = -x; end
      default: begin sn = -x; cs = y; end
    endcase
  endfunction

  // Weighted trig term divided by x, with the magnitude clamp.
  function automatic longint term_over_x(input longint term, input logic [63:0] x24);
    logic [63:0] mg;
    logic [63:0] q;
    mg = (term < 0) ? -term : term;
    q = (mg << 2) / x24;
    if (term < 0) return (q > (64'd1 << 47)) ? NEG48 : -longint'(q);
    return (q > 64'h0000_7FFF_FFFF_FFFF) ? POS48 : longint'(q);
  endfunction

  // Add one source to the running sums; on the last source queue the potential.
  function automatic void accumulate_source(input hps_in_t b);
    longint      dx, dy, dz, sn, cs, str;
    logic [63:0] ax, ay, az, m, d, x24;
    logic [127:0] p;
    int          s;
    hps_out_t    r;
    dx = longint'(b.source_x) - longint'(b.target_x);
    dy = longint'(b.source_y) - longint'(b.target_y);
    dz = longint'(b.source_z) - longint'(b.target_z);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    az = (dz < 0) ? -dz : dz;
    m = ax;
    if (ay > m) m = ay;
    if (az > m) m = az;
    s = 0;
    while ((m >> s) >= 64'h8000_0000) s++;
    ax = ax >> s; ay = ay >> s; az = az >> s;
    d = int_sqrt(ax * ax + ay * ay + az * az) << s;
    p = 128'(wavenumber_now) * 128'(d);
    x24 = p[79:16];
    if (x24 != 0) begin
      p = 128'(x24) * 128'(INV_TWO_PI_Q64);
      sin_cos(p[87:56], sn, cs);
      str = longint'(b.source_strength);
      sum_re = clamp48(sum_re + term_over_x(str * sn, x24));
      sum_im = clamp48(sum_im + term_over_x(str * cs, x24));
    end
    if (b.last_source) begin
      r.phi_real = 48'(clamp48(longint'(b.prior_phi_real) + sum_re));
      r.phi_imag = 48'(clamp48(longint'(b.prior_phi_imag) + sum_im));
      potentials_due.push_back(r);
      sum_re = 0;
      sum_im = 0;
    end
  endfunction

  // Source beat driver: predicts on every accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accumulate_source(in_data);
        beats_sent++;
      end
      if (!in_valid || in_ready) begin
        if (source_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= source_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    hps_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (potentials_due.size() == 0) begin
          $error("unexpected result beat phi_real=%0d phi_imag=%0d",
                 out_data.phi_real, out_data.phi_imag);
          failures++;
        end else begin
          want = potentials_due.pop_front();
          if (out_data.phi_real !== want.phi_real) begin
            $error("phi_real expected %0d actual %0d", want.phi_real, out_data.phi_real);
            failures++;
          end
          if (out_data.phi_imag !== want.phi_imag) begin
            $error("phi_imag expected %0d actual %0d", want.phi_imag, out_data.phi_imag);
            failures++;
          end
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("helmholtz_potential_sum verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] near_offset(input logic signed [31:0] base);
    return base + 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
  endfunction

  // One well-formed list of sources for a single target.
  task automatic queue_list(input int len);
    hps_in_t b;
    b.target_x = $urandom;
    b.target_y = $urandom;
    b.target_z = $urandom;
    b.prior_phi_real = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) :
                       48'($signed($urandom_range(0, 2 ** 28)) - 2 ** 27);
    b.prior_phi_imag = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) :
                       48'($signed($urandom_range(0, 2 ** 28)) - 2 ** 27);
    for (int i = 0; i < len; i++) begin
      b.source_strength = ($urandom_range(3) == 0) ? $urandom :
                          32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17);
      case ($urandom_range(5))
        0: begin
          b.source_x = $urandom; b.source_y = $urandom; b.source_z = $urandom;
        end
        1: begin
          b.source_x = b.target_x; b.source_y = b.target_y; b.source_z = b.target_z;
        end
        default: begin
          b.source_x = near_offset(b.target_x);
          b.source_y = near_offset(b.target_y);
          b.source_z = near_offset(b.target_z);
        end
      endcase
      b.last_source = (i == len - 1);
      source_beats.push_back(b);
    end
  endtask

  task automatic fill_random(input int n_beats);
    hps_in_t junk;
    int start;
    start = source_beats.size();
    while (source_beats.size() - start < n_beats) begin
      if ($urandom_range(9) == 0) begin
        // Fully random beat, possibly breaking the current list.
        junk.target_x        = $urandom;
        junk.target_y        = $urandom;
        junk.target_z        = $urandom;
        junk.source_strength = $urandom;
        junk.source_x        = $urandom;
        junk.source_y        = $urandom;
        junk.source_z        = $urandom;
        junk.prior_phi_real  = 48'({$urandom, $urandom});
        junk.prior_phi_imag  = 48'({$urandom, $urandom});
        junk.last_source     = 1'($urandom_range(1));
        source_beats.push_back(junk);
      end else begin
        queue_list($urandom_range(1, 8));
      end
    end
  endtask

  task automatic wait_idle();
    while (source_beats.size() != 0 || in_valid || potentials_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_wavenumber(input logic [31:0] k);
    cfg_valid <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    wavenumber_now = k;
    cfg_valid <= 1'b0;
  endtask

  task automatic push_beat(input logic signed [31:0] tx, ty, tz, st, sx, sy, sz,
                           input logic signed [47:0] pr, pi, input logic last);
    hps_in_t b;
    b = '{tx, ty, tz, st, sx, sy, sz, pr, pi, last};
    source_beats.push_back(b);
  endtask

  initial begin
    logic signed [31:0] mx;
    logic signed [31:0] mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    wavenumber_now = WAVENUMBER_RST;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset wavenumber.
    push_beat(5, 6, 7, mx, 5, 6, 7, 0, 0, 1);                 // coincident source
    push_beat(mn, mn, mn, mx, mx, mx, mx, 0, 0, 1);           // widest distance
    push_beat(mx, mx, mx, mn, mn, mn, mn, 0, 0, 1);
    push_beat(0, 0, 0, mx, 1, 0, 0, 0, 0, 0);                 // one-LSB distance
    push_beat(0, 0, 0, mx, 0, 1, 0, 0, 0, 0);
    push_beat(0, 0, 0, mx, 0, 0, 1, SAT_MAX, SAT_MAX, 1);     // saturating sums
    push_beat(0, 0, 0, mn, 1, 1, 1, 0, 0, 0);
    push_beat(0, 0, 0, mn, -1, -1, -1, SAT_MIN, SAT_MIN, 1);
    push_beat(0, 0, 0, 0, 32'sh10000, 0, 0, -1, -1, 1);       // zero strength
    push_beat(100, 200, 300, 32'sh10000, 32'sh30000, 200, 300, 0, 0, 0);
    push_beat(100, 200, 300, -32'sh10000, 100, 32'sh50000, 300, 0, 0, 0);
    push_beat(100, 200, 300, 32'sh20000, 100, 200, 32'sh70000, 48'sh1234, 48'sh5678, 1);
    push_beat(-1, -1, -1, 32'sh8000, 32'sh7FFF_0000, 0, 0, 0, 0, 1);
    wait_idle();

    // Random phases over several wavenumbers and handshake patterns.
    write_wavenumber(32'h0100_0000);
    fill_random(170);
    wait_idle();

    write_wavenumber(32'hFFFF_FFFF);
    sender_idle_pct = 62;
    fill_random(170);
    wait_idle();

    write_wavenumber(32'h0000_0000);
    sender_idle_pct = 0;
    recv_stall_pct = 62;
    fill_random(120);
    wait_idle();

    write_wavenumber(32'h0000_0001);
    sender_idle_pct = 11;
    recv_stall_pct = 11;
    fill_random(120);
    wait_idle();

    // Long receiver hold-off while beats keep arriving, then both sides idle.
    write_wavenumber($urandom);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (4000) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    fill_random(120);
    wait_idle();

    write_wavenumber($urandom);
    sender_idle_pct = 62;
    recv_stall_pct = 62;
    fill_random(170);
    wait_idle();

    write_wavenumber($urandom_range(32'h0010_0000, 32'h0400_0000));
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    fill_random(120);
    wait_idle();

    $display("Sent %0d source beats over seven wavenumber settings; %0d potentials checked.",
             beats_sent, results_seen);
    if (failures == 0 && potentials_due.size() == 0) begin
      $display("helmholtz_potential_sum verification clean");
    end else begin
      $display("helmholtz_potential_sum verification failed");
    end
    $finish;
  end

endmodule

### helmholtz_potential_sum.f
rtl/hps_pkg.sv
rtl/hps_isqrt.sv
rtl/hps_cordic.sv
rtl/hps_div.sv
rtl/helmholtz_potential_sum.sv
tb/helmholtz_potential_sum_tb.sv
